[hdl/text_console_writer_defines.svh]
// Assertion macros used by the text console writer back end.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication check.
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer: same-cycle check failed");

// Next-cycle implication check.
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console writer: next-cycle check failed");

`else

`define TCW_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Limits applied to the column and memory size registers.
   localparam int MAX_CELLS   = 65536;
   localparam int MAX_COLUMNS = 128;

   // Field and datapath widths.
   localparam int OFFSET_W    = 16;
   localparam int COLUMN_W    = 7;
   localparam int COLS_W      = 8;
   localparam int ROWS_W      = 7;
   localparam int MEM_W       = 17;
   localparam int SCREEN_W    = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;
   localparam int REM_DVD_W   = 18;
   localparam int REM_DVS_W   = 17;
   localparam int REM_OUT_W   = 16;

   // Character and operation codes.
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic       OP_CHAR      = 1'b0;
   localparam logic       OP_END       = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_CELL  = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEMORY_CELLS = 2'd2;

   // Input transaction payload.
   typedef struct packed {
      logic       operation;
      logic [7:0] char_code;
      logic [7:0] attribute;
   } req_payload_type;

   // Result transaction payload.
   typedef struct packed {
      logic [1:0]          kind;
      logic [OFFSET_W-1:0] address;
      logic [7:0]          run_length;
      logic [15:0]         cell_value;
      logic                last;
   } rsp_payload_type;

   // Item classes decided by the front end.
   typedef enum logic [1:0] {
      CLASS_CHAR,
      CLASS_NEWLINE,
      CLASS_END
   } cmd_class_type;

   // Classified item held in the queue.
   typedef struct packed {
      cmd_class_type cls;
      logic [7:0]    code;
      logic [7:0]    attribute;
   } cmd_type;

   // Remainder unit request and response.
   typedef struct packed {
      logic                 start;
      logic [REM_DVD_W-1:0] dividend;
      logic [REM_DVS_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic                 done;
      logic [REM_OUT_W-1:0] remainder;
   } rem_rsp_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_RUN,
      ST_REDUCE,
      ST_FILL,
      ST_CHECK,
      ST_START,
      ST_NORM_WO,
      ST_NORM_DS,
      ST_NORM_SCR
   } back_state_type;

endpackage

[hdl/tcw_front.sv]
// Front end: classifies incoming transactions and queues them for the back end.
`timescale 1ns / 1ps

module tcw_front #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tcw_pkg::req_payload_type req_data,
   output logic                     cmd_valid,
   output tcw_pkg::cmd_type         cmd_data,
   input  logic                     cmd_pop
);
   import tcw_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            cmd_new;
   logic               push;

   // Decide what kind of work the transaction asks for.
   always_comb begin
      cmd_new.code      = req_data.char_code;
      cmd_new.attribute = req_data.attribute;
      if (req_data.operation == OP_END) begin
         cmd_new.cls = CLASS_END;
      end else if (req_data.char_code == NEWLINE_CODE) begin
         cmd_new.cls = CLASS_NEWLINE;
      end else begin
         cmd_new.cls = CLASS_CHAR;
      end
   end

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = entries_ff[rd_ptr_ff];

   // Queue pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[hdl/tcw_rem.sv]
// Bit-serial remainder unit used for offset and screen size reduction.
`timescale 1ns / 1ps

module tcw_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_pkg::rem_req_type rem_req,
   output tcw_pkg::rem_rsp_type rem_rsp
);
   import tcw_pkg::*;

   localparam int CNT_W = $clog2(REM_DVD_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [REM_DVD_W-1:0] dvd_ff, dvd_in;
   logic [REM_DVS_W-1:0] dvs_ff, dvs_in;
   logic [REM_OUT_W-1:0] acc_ff, acc_in;
   logic [REM_OUT_W:0]   acc_shift;
   logic [REM_OUT_W:0]   acc_diff;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   assign acc_shift = {acc_ff, dvd_ff[REM_DVD_W-1]};
   assign acc_diff  = acc_shift - dvs_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      acc_in  = acc_ff;
      if (rem_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(REM_DVD_W - 1);
         dvd_in  = rem_req.dividend;
         dvs_in  = rem_req.divisor;
         acc_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[REM_DVD_W-2:0], 1'b0};
         acc_in = (acc_shift >= dvs_ff) ? acc_diff[REM_OUT_W-1:0]
                                         : acc_shift[REM_OUT_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      acc_ff <= acc_in;
   end

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = acc_ff;

endmodule

[hdl/tcw_back.sv]
// Back end: configuration registers, console state and result generation.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              cmd_valid,
   input  tcw_pkg::cmd_type                  cmd_data,
   output logic                              cmd_pop,
   output tcw_pkg::rem_req_type              rem_req,
   input  tcw_pkg::rem_rsp_type              rem_rsp,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tcw_pkg::rsp_payload_type          rsp_data
);
   import tcw_pkg::*;

   // Configuration registers.
   logic [COLS_W-1:0]   cols_ff, cols_in;
   logic [ROWS_W-1:0]   rows_ff, rows_in;
   logic [MEM_W-1:0]    mem_ff, mem_in;

   // Console state.
   back_state_type      state_ff, state_in;
   logic                dirty_ff, dirty_in;
   logic [OFFSET_W-1:0] wo_ff, wo_in;
   logic [OFFSET_W-1:0] ds_ff, ds_in;
   logic [COLUMN_W-1:0] col_ff, col_in;
   logic [SCREEN_W-1:0] screen_ff, screen_in;
   logic [SCREEN_W-1:0] smod_ff, smod_in;

   // Pending fill and output register.
   logic [OFFSET_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]          pend_run_ff, pend_run_in;
   logic [7:0]          pend_attr_ff, pend_attr_in;
   logic                pend_end_ff, pend_end_in;
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   // Derived values.
   logic [COLS_W-1:0]   eff_cols;
   logic [ROWS_W-1:0]   eff_rows;
   logic [MEM_W-1:0]    eff_mem;
   logic [SCREEN_W:0]   screen_prod;
   logic                out_free;
   logic [COLS_W-1:0]   fill_run;
   logic [OFFSET_W:0]   fill_sum;
   logic [OFFSET_W:0]   fill_wrap;
   logic                sum_lt_mem;
   logic                sum_lt_2mem;
   logic [OFFSET_W:0]   wo_inc;
   logic [COLS_W-1:0]   col_inc;
   logic [OFFSET_W:0]   end_addr;
   logic [OFFSET_W+1:0] wrap_sum;
   logic                off_screen;
   logic [OFFSET_W-1:0] new_start;
   logic                settled;

   // Register values as the datapath uses them.
   always_comb begin
      if (cols_ff == '0) begin
         eff_cols = COLS_W'(1);
      end else if (cols_ff > COLS_W'(MAX_COLUMNS)) begin
         eff_cols = COLS_W'(MAX_COLUMNS);
      end else begin
         eff_cols = cols_ff;
      end
      eff_rows = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;
      if (mem_ff == '0) begin
         eff_mem = MEM_W'(1);
      end else if (mem_ff > MEM_W'(MAX_CELLS)) begin
         eff_mem = MEM_W'(MAX_CELLS);
      end else begin
         eff_mem = mem_ff;
      end
   end

   assign screen_prod = (SCREEN_W + 1)'(eff_cols) * (SCREEN_W + 1)'(eff_rows);
   assign out_free    = !out_valid_ff || rsp_ready;

   // Next write offset and column for characters and fills.
   assign fill_run    = eff_cols - COLS_W'(col_ff);
   assign fill_sum    = (OFFSET_W + 1)'(wo_ff) + (OFFSET_W + 1)'(fill_run);
   assign fill_wrap   = fill_sum - eff_mem;
   assign sum_lt_mem  = fill_sum < eff_mem;
   assign sum_lt_2mem = {1'b0, fill_sum} < {eff_mem, 1'b0};
   assign wo_inc      = (OFFSET_W + 1)'(wo_ff) + 1'b1;
   assign col_inc     = COLS_W'(col_ff) + 1'b1;

   // Wrap-aware visibility check and the display start that follows it.
   assign end_addr   = (OFFSET_W + 1)'(ds_ff) + (OFFSET_W + 1)'(screen_ff);
   assign wrap_sum   = (OFFSET_W + 2)'(wo_ff) + (OFFSET_W + 2)'(eff_mem);
   assign off_screen = ((OFFSET_W + 1)'(wo_ff) > end_addr) ||
                       ((wo_ff < ds_ff) && (wrap_sum > (OFFSET_W + 2)'(end_addr)));
   assign new_start  = (wo_ff >= OFFSET_W'(smod_ff)) ? wo_ff - OFFSET_W'(smod_ff)
                     : OFFSET_W'(wrap_sum - (OFFSET_W + 2)'(smod_ff));

   // Sequencer: next state, state updates and result emission.
   always_comb begin
      state_in     = state_ff;
      dirty_in     = dirty_ff;
      wo_in        = wo_ff;
      ds_in        = ds_ff;
      col_in       = col_ff;
      screen_in    = screen_ff;
      smod_in      = smod_ff;
      pend_addr_in = pend_addr_ff;
      pend_run_in  = pend_run_ff;
      pend_attr_in = pend_attr_ff;
      pend_end_in  = pend_end_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      rem_req.start    = 1'b0;
      rem_req.dividend = REM_DVD_W'(wo_ff);
      rem_req.divisor  = eff_mem;

      case (state_ff)
         ST_RUN: begin
            if (dirty_ff) begin
               // Registers changed: reduce the offsets and screen size again.
               // A write that lands during the pass marks the state dirty again.
               rem_req.start    = 1'b1;
               rem_req.dividend = REM_DVD_W'(wo_ff);
               screen_in        = SCREEN_W'(screen_prod);
               dirty_in         = 1'b0;
               state_in         = ST_NORM_WO;
            end else if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd_data.cls)
                  CLASS_CHAR: begin
                     out_valid_in       = 1'b1;
                     rsp_in.kind        = KIND_CELL;
                     rsp_in.address     = wo_ff;
                     rsp_in.run_length  = 8'd1;
                     rsp_in.cell_value  = {cmd_data.attribute, cmd_data.code};
                     rsp_in.last        = 1'b1;
                     wo_in  = (wo_inc == eff_mem) ? '0 : wo_inc[OFFSET_W-1:0];
                     col_in = (col_inc >= eff_cols) ? '0 : col_inc[COLUMN_W-1:0];
                  end
                  CLASS_NEWLINE, CLASS_END: begin
                     pend_addr_in = wo_ff;
                     pend_run_in  = fill_run;
                     pend_attr_in = cmd_data.attribute;
                     pend_end_in  = (cmd_data.cls == CLASS_END);
                     col_in       = '0;
                     if (sum_lt_2mem) begin
                        wo_in = sum_lt_mem ? fill_sum[OFFSET_W-1:0]
                                           : fill_wrap[OFFSET_W-1:0];
                        if (cmd_data.cls == CLASS_END) begin
                           state_in = ST_CHECK;
                        end else begin
                           out_valid_in      = 1'b1;
                           rsp_in.kind       = KIND_FILL;
                           rsp_in.address    = wo_ff;
                           rsp_in.run_length = fill_run;
                           rsp_in.cell_value = {cmd_data.attribute, 8'h00};
                           rsp_in.last       = 1'b1;
                        end
                     end else begin
                        // The run wraps the memory more than once.
                        rem_req.start    = 1'b1;
                        rem_req.dividend = REM_DVD_W'(fill_sum);
                        state_in         = ST_REDUCE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            if (rem_rsp.done) begin
               wo_in    = rem_rsp.remainder;
               state_in = pend_end_ff ? ST_CHECK : ST_FILL;
            end
         end
         ST_FILL: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               rsp_in.kind       = KIND_FILL;
               rsp_in.address    = pend_addr_ff;
               rsp_in.run_length = pend_run_ff;
               rsp_in.cell_value = {pend_attr_ff, 8'h00};
               rsp_in.last       = 1'b1;
               state_in          = ST_RUN;
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               rsp_in.kind       = KIND_FILL;
               rsp_in.address    = pend_addr_ff;
               rsp_in.run_length = pend_run_ff;
               rsp_in.cell_value = {pend_attr_ff, 8'h00};
               rsp_in.last       = !off_screen;
               if (off_screen) begin
                  ds_in    = new_start;
                  state_in = ST_START;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_START: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               rsp_in.kind       = KIND_START;
               rsp_in.address    = ds_ff;
               rsp_in.run_length = '0;
               rsp_in.cell_value = '0;
               rsp_in.last       = 1'b1;
               state_in          = ST_RUN;
            end
         end
         ST_NORM_WO: begin
            if (rem_rsp.done) begin
               wo_in            = rem_rsp.remainder;
               rem_req.start    = 1'b1;
               rem_req.dividend = REM_DVD_W'(ds_ff);
               state_in         = ST_NORM_DS;
            end
         end
         ST_NORM_DS: begin
            if (rem_rsp.done) begin
               ds_in            = rem_rsp.remainder;
               rem_req.start    = 1'b1;
               rem_req.dividend = REM_DVD_W'(screen_ff);
               state_in         = ST_NORM_SCR;
            end
         end
         ST_NORM_SCR: begin
            if (rem_rsp.done) begin
               smod_in  = SCREEN_W'(rem_rsp.remainder);
               if (COLS_W'(col_ff) >= eff_cols) begin
                  col_in = COLUMN_W'(eff_cols - 1'b1);
               end
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      // Any register write forces a new reduction pass.
      if (csr_we) begin
         dirty_in = 1'b1;
      end
   end

   // Configuration writes.
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      mem_in  = mem_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS:      cols_in = csr_wdata[COLS_W-1:0];
            CSR_ROWS:         rows_in = csr_wdata[ROWS_W-1:0];
            CSR_MEMORY_CELLS: mem_in  = csr_wdata[MEM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= COLS_W'(80);
         rows_ff      <= ROWS_W'(25);
         mem_ff       <= MEM_W'(65520);
         state_ff     <= ST_RUN;
         dirty_ff     <= 1'b1;
         wo_ff        <= '0;
         ds_ff        <= '0;
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         mem_ff       <= mem_in;
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         wo_ff        <= wo_in;
         ds_ff        <= ds_in;
         col_ff       <= col_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      screen_ff    <= screen_in;
      smod_ff      <= smod_in;
      pend_addr_ff <= pend_addr_in;
      pend_run_ff  <= pend_run_in;
      pend_attr_ff <= pend_attr_in;
      pend_end_ff  <= pend_end_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // The console state is reduced and waiting for work.
   assign settled = (state_ff == ST_RUN) && !dirty_ff;

   // Offsets and column stay inside the configured geometry once reduced.
   `TCW_ASSERT_IMP(a_offset_in_range, clock, reset, settled, MEM_W'(wo_ff) < eff_mem)
   `TCW_ASSERT_IMP(a_start_in_range, clock, reset, settled, MEM_W'(ds_ff) < eff_mem)
   `TCW_ASSERT_IMP(a_column_in_range, clock, reset, settled, COLS_W'(col_ff) < eff_cols)
   // A display start is only announced right after the closing fill.
   `TCW_ASSERT_NXT(a_start_after_check, clock, reset, (state_ff != ST_CHECK) && (state_ff != ST_START), state_ff != ST_START)

endmodule

[hdl/text_console_writer.sv]
// Top level of the text console writer.
`timescale 1ns / 1ps

// Turns message characters into cell writes, blank fill runs and display start moves
// for a circular text memory. Characters and newlines are taken one per clock while
// the queue has room; an accepted transaction is first stored in the queue and then
// turned by the back end into a result in the output register. The queue between
// front and back end and the output register keep input and output flowing
// independently. An end-of-message item passes the back end's check state, and also
// its start state when the display start moves. A fill run that passes the memory
// end more than once (memory smaller than the run) goes through the bit-serial
// remainder unit. After reset and after every configuration write the back end
// reduces the write offset, the display start and the screen size by the memory
// size in three remainder passes while queued items wait; a write that lands
// during such a pass starts another full pass once it ends.
module text_console_writer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tcw_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tcw_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcw_pkg::*;

   logic        cmd_valid;
   cmd_type     cmd_data;
   logic        cmd_pop;
   rem_req_type rem_req;
   rem_rsp_type rem_rsp;

   // Classification and queue.
   tcw_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // Shared remainder unit.
   tcw_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   // Console state and result generation.
   tcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rem_req   (rem_req),
      .rem_rsp   (rem_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/text_console_writer_tb.sv]
// Self-checking testbench for the text console writer.
`timescale 1ns / 1ps

module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_STALL     = 300;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 136;
   localparam int REPORT_LIMIT   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Transactions waiting for the driver and cell writes waiting for the monitor.
   req_payload_type pending_items[$];
   rsp_payload_type expected_writes[$];

   // Shadow copy of the block's registers and running console state.
   int unsigned shadow_columns;
   int unsigned shadow_rows;
   int unsigned shadow_memory;
   int unsigned shadow_offset;
   int unsigned shadow_column;
   int unsigned shadow_start;

   // Idle percentages and the long receiver hold-off request.
   int unsigned sender_idle_pct   = 27;
   int unsigned receiver_idle_pct = 81;
   int unsigned stall_request     = 0;
   int unsigned stall_left        = 0;

   int unsigned items_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned cell_writes     = 0;
   int unsigned fill_runs       = 0;
   int unsigned start_moves     = 0;
   int unsigned mismatches      = 0;
   int unsigned settings_used   = 1;
   int unsigned quiet_cycles    = 0;

   text_console_writer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Works out the cell writes, fill runs and start moves that one transaction causes.
   function automatic void predict_console_writes(input req_payload_type item);
      int unsigned cols;
      int unsigned mem;
      int unsigned lines;
      int unsigned run;
      int unsigned fill_addr;
      int unsigned screen;
      int unsigned limit;
      int unsigned wrap_screen;
      int unsigned new_start;
      rsp_payload_type w;
      cols  = (shadow_columns == 0) ? 1 :
              ((shadow_columns > MAX_COLUMNS) ? MAX_COLUMNS : shadow_columns);
      mem   = (shadow_memory == 0) ? 1 :
              ((shadow_memory > MAX_CELLS) ? MAX_CELLS : shadow_memory);
      lines = (shadow_rows == 0) ? 1 : shadow_rows;

      // A register change may leave offsets or the column out of range.
      shadow_offset = shadow_offset % mem;
      shadow_start  = shadow_start % mem;
      if (shadow_column >= cols) begin
         shadow_column = cols - 1;
      end

      // An ordinary character writes one cell.
      if (item.operation == OP_CHAR && item.char_code != NEWLINE_CODE) begin
         w.kind       = KIND_CELL;
         w.address    = shadow_offset[15:0];
         w.run_length = 8'd1;
         w.cell_value = {item.attribute, item.char_code};
         w.last       = 1'b1;
         expected_writes.push_back(w);
         shadow_offset = (shadow_offset + 1) % mem;
         shadow_column = shadow_column + 1;
         if (shadow_column >= cols) begin
            shadow_column = 0;
         end
         return;
      end

      // A newline or end of message blanks the rest of the line.
      run           = cols - shadow_column;
      fill_addr     = shadow_offset;
      shadow_offset = (shadow_offset + run) % mem;
      shadow_column = 0;
      w.kind        = KIND_FILL;
      w.address     = fill_addr[15:0];
      w.run_length  = run[7:0];
      w.cell_value  = {item.attribute, 8'h00};
      w.last        = 1'b1;

      // At the end of a message, scroll when the output has left the visible window.
      if (item.operation == OP_END) begin
         screen = cols * lines;
         limit  = shadow_start + screen;
         if (shadow_offset > limit ||
             (shadow_offset < shadow_start && shadow_offset + mem > limit)) begin
            w.last = 1'b0;
            expected_writes.push_back(w);
            wrap_screen  = screen % mem;
            new_start    = (shadow_offset >= wrap_screen) ? shadow_offset - wrap_screen :
                           shadow_offset + mem - wrap_screen;
            shadow_start = new_start;
            w.kind       = KIND_START;
            w.address    = new_start[15:0];
            w.run_length = 8'd0;
            w.cell_value = 16'd0;
            w.last       = 1'b1;
         end
      end
      expected_writes.push_back(w);
   endfunction

   // Compares one result transaction with the oldest expectation.
   function automatic void check_console_write(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_writes.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result with nothing outstanding: kind %0d addr %0d run %0d value %h last %0d",
                     $realtime, got.kind, got.address, got.run_length, got.cell_value, got.last);
         end
         return;
      end
      want = expected_writes.pop_front();
      results_checked++;
      if (got.kind !== want.kind || got.address !== want.address ||
          got.run_length !== want.run_length || got.cell_value !== want.cell_value ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result %0d expected kind %0d addr %0d run %0d value %h last %0d",
                     $realtime, results_checked, want.kind, want.address, want.run_length,
                     want.cell_value, want.last);
            $display("%0t: result %0d actual   kind %0d addr %0d run %0d value %h last %0d",
                     $realtime, results_checked, got.kind, got.address, got.run_length,
                     got.cell_value, got.last);
         end
      end
      case (got.kind)
         KIND_CELL:  cell_writes++;
         KIND_FILL:  fill_runs++;
         KIND_START: start_moves++;
         default: ;
      endcase
   endfunction

   function automatic void queue_item(input logic op, input logic [7:0] code,
                                      input logic [7:0] attr);
      req_payload_type item;
      item.operation = op;
      item.char_code = code;
      item.attribute = attr;
      pending_items.push_back(item);
   endfunction

   // Mostly whole messages with random text, plus stray items and cut-off messages.
   task automatic queue_random_traffic(input int count);
      int queued;
      int msg_len;
      logic [7:0] attr;
      logic [7:0] code;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(99) < 85) begin
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24);
            attr    = 8'($urandom);
            for (int i = 0; i < msg_len && queued < count; i++) begin
               code = ($urandom_range(7) == 0) ? NEWLINE_CODE : 8'($urandom);
               queue_item(OP_CHAR, code, attr);
               queued++;
            end
            if (queued < count && $urandom_range(19) != 0) begin
               queue_item(OP_END, 8'($urandom), attr);
               queued++;
            end
         end else begin
            queue_item(1'($urandom), 8'($urandom), 8'($urandom));
            queued++;
         end
      end
   endtask

   // Waits until every transaction is sent and answered, then lets the block settle.
   task automatic wait_for_idle();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_valid || expected_writes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (index)
         CSR_COLUMNS:      shadow_columns = value & 32'hFF;
         CSR_ROWS:         shadow_rows    = value & 32'h7F;
         CSR_MEMORY_CELLS: shadow_memory  = value & 32'h1FFFF;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input int unsigned cols, input int unsigned lines,
                                input int unsigned cells);
      write_register(CSR_COLUMNS, cols);
      write_register(CSR_ROWS, lines);
      write_register(CSR_MEMORY_CELLS, cells);
      settings_used++;
      @(negedge clock);
   endtask

   // Driver: predicts each accepted transaction and offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_console_writes(req_data);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result and paces the ready signal.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_console_write(rsp_data);
         end
         if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results still outstanding",
                  $realtime, quiet_cycles, expected_writes.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus sequence.
   initial begin
      int unsigned cols;
      shadow_columns = 80;
      shadow_rows    = 25;
      shadow_memory  = 65520;
      shadow_offset  = 0;
      shadow_column  = 0;
      shadow_start   = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items on the reset settings: byte extremes, newline and end of message.
      queue_item(OP_CHAR, 8'h00, 8'h00);
      queue_item(OP_CHAR, 8'hFF, 8'hFF);
      queue_item(OP_CHAR, NEWLINE_CODE, 8'h1E);
      queue_item(OP_CHAR, 8'h41, 8'h07);
      queue_item(OP_END, 8'hFF, 8'h70);
      wait_for_idle();

      // Tiny screen on a memory that is not a multiple of the line: scrolls and wraps.
      apply_setting(4, 1, 10);
      queue_item(OP_CHAR, 8'h61, 8'hA5);
      queue_item(OP_CHAR, 8'h62, 8'h5A);
      queue_item(OP_END, 8'h00, 8'h01);
      queue_item(OP_END, NEWLINE_CODE, 8'h02);
      queue_item(OP_END, 8'h55, 8'h80);
      queue_item(OP_CHAR, 8'h80, 8'h0F);
      queue_item(OP_CHAR, 8'h7F, 8'hF0);
      queue_item(OP_CHAR, NEWLINE_CODE, 8'hC3);
      queue_item(OP_CHAR, 8'h0B, 8'h3C);
      queue_item(OP_CHAR, 8'h31, 8'h11);
      queue_item(OP_CHAR, 8'h32, 8'h22);
      queue_item(OP_CHAR, 8'h33, 8'h33);
      queue_item(OP_CHAR, 8'h34, 8'h44);
      queue_item(OP_END, NEWLINE_CODE, 8'hEE);
      queue_item(OP_END, 8'hAA, 8'h77);

      // Random phases, each on its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_idle();
         if (phase < 4) begin
            sender_idle_pct   = 27;
            receiver_idle_pct = 81;
         end else if (phase < 8) begin
            sender_idle_pct   = 81;
            receiver_idle_pct = 27;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         case (phase)
            0: apply_setting(128, 64, 65536);
            1: apply_setting(1, 1, 1);
            2: apply_setting(0, 0, 0);
            3: apply_setting(255, 127, 131071);
            4: apply_setting(7, 3, 50);
            5: apply_setting(16, 8, 64);
            6: apply_setting(80, 25, 65520);
            default: begin
               cols = $urandom_range(1, 128);
               if ($urandom_range(3) == 0) begin
                  apply_setting(cols, $urandom_range(1, 64), $urandom_range(1, 65536));
               end else begin
                  apply_setting(cols, $urandom_range(1, 64), cols * $urandom_range(1, 12));
               end
            end
         endcase
         if (phase == 9) begin
            // Sender pauses halfway until every result is back.
            queue_random_traffic(PHASE_ITEMS / 2);
            wait_for_idle();
            queue_random_traffic(PHASE_ITEMS / 2);
         end else begin
            queue_random_traffic(PHASE_ITEMS);
            if (phase == 8) begin
               // Receiver holds off while the sender keeps offering.
               stall_request = LONG_STALL;
            end
         end
      end

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d input transactions over %0d register settings, %0d results checked:",
               items_accepted, settings_used, results_checked);
      $display("%0d cell writes, %0d fill runs, %0d display start moves, %0d mismatches.",
               cell_writes, fill_runs, start_moves, mismatches);
      if (mismatches == 0 && expected_writes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[text_console_writer.f]
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_rem.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
tb/sv/text_console_writer_tb.sv
